/* rtl/vhrg_pkg.sv */
// Package for the voice hold/release gate: beat payload types, action codes,
// mode codes and the divide-by-frame-size helper. No dependencies.
package vhrg_pkg;

	localparam logic [7:0] ALG_CLEAR = 8'h80;
	localparam int FRAME_SAMPLES = 160;

	localparam logic [2:0] MODE_HEADER = 3'd0;
	localparam logic [2:0] MODE_SAMPLE = 3'd1;
	localparam logic [2:0] MODE_TICK   = 3'd2;
	localparam logic [2:0] MODE_END    = 3'd3;
	localparam logic [2:0] MODE_DRAIN  = 3'd4;

	localparam logic [1:0] CFG_OUTPUT_CAP = 2'd0;
	localparam logic [1:0] CFG_MAX_AGE    = 2'd1;

	localparam logic [13:0] CAP_RESET = 14'd4096;
	localparam logic [15:0] AGE_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ACT_PASS    = 2'd0,
		ACT_HOLD    = 2'd1,
		ACT_DROP    = 2'd2,
		ACT_RELEASE = 2'd3
	} act_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [15:0] sample_in;
		logic [13:0]        frame_len;
		logic               unproven;
		logic               sync_valid;
		logic [7:0]         algorithm_id;
		logic [15:0]        talkgroup;
		logic [31:0]        now_ms;
	} in_t;

	typedef struct packed {
		logic               out_valid;
		logic signed [15:0] out_sample;
		logic               drain_last;
		act_t               frame_action;
		logic [12:0]        held_count;
		logic [31:0]        frames_held;
		logic [31:0]        frames_released;
		logic [31:0]        frames_discarded;
	} out_t;

	// Result of the control stage; from_ring says the sample comes from the ring read.
	typedef struct packed {
		out_t item;
		logic from_ring;
	} ctrl_res_t;

	// x / 160 as (x >> 5) / 5 by reciprocal multiply; exact for x below 2^17.
	function automatic logic [31:0] div160(input logic [16:0] x);
		logic [11:0] y;
		logic [27:0] p;
		begin
			y = x[16:5];
			p = 28'(y) * 28'd52429;
			div160 = 32'(p[27:18]);
		end
	endfunction

endpackage

/* rtl/voice_hold_release_gate_unit.sv */
// Voice hold/release gate: a result goes through the stage-1 and output registers.
// Throughput: one beat per clock unless the output stalls; the state update is a
// read-modify-write and the ring read lands with the stage-1 result. Reset clears all
// counters and gate state at once; ring contents are kept, needing no clearing pass.
module voice_hold_release_gate_unit #(
	parameter int HOLD_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  vhrg_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output vhrg_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import vhrg_pkg::*;

	localparam int AW = $clog2(HOLD_DEPTH);
	localparam int FW = $clog2(HOLD_DEPTH + 1);

	logic          acc, adv;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, rdata;
	ctrl_res_t     res, res_s1;
	logic          valid_s1;
	out_t          out_d;
	out_t          out_q;
	logic          out_valid_q;

	// Stage 1 moves whenever the output register is empty or being taken.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	vhrg_ctrl #(.DEPTH(HOLD_DEPTH), .AW(AW), .FW(FW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .acc(acc), .item(in_data),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.mem_re(mem_re), .mem_raddr(mem_raddr), .res(res)
	);

	vhrg_ring #(.DEPTH(HOLD_DEPTH), .AW(AW)) u_ring (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid_q <= valid_s1;
		end
	end

	always_comb begin
		out_d = res_s1.item;
		if (res_s1.from_ring) out_d.out_sample = rdata;
	end

	always_ff @(posedge clk) begin
		if (acc) res_s1 <= res;
		if (adv && valid_s1) out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

/* rtl/vhrg_ring.sv */
// Hold ring storage: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module vhrg_ring #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [15:0]       rdata
);
	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/vhrg_ctrl.sv */
// Gate control: per-beat state update, frame decisions, counters, config registers
// and ring address generation. Uses vhrg_pkg.
module vhrg_ctrl #(
	parameter int DEPTH = 4096,
	parameter int AW = 12,
	parameter int FW = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  vhrg_pkg::in_t       item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [15:0]         mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	output vhrg_pkg::ctrl_res_t res
);
	import vhrg_pkg::*;

	localparam int XW = FW + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [13:0]   cap_q;
	logic [15:0]   age_q;
	logic [AW-1:0] head_q, head_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [15:0]   htg_q, htg_d;
	logic [31:0]   ltime_q, ltime_d;
	logic [31:0]   held_q, held_d, rel_q, rel_d, disc_q, disc_d;
	act_t          act_q, act_d;
	logic [13:0]   emit_q, emit_d;
	logic [FW-1:0] drain_q, drain_d;
	logic [13:0]   frem_q, frem_d;

	always_comb begin
		logic [31:0]   fill_div, n_div;
		logic          tgchg;
		logic [XW-1:0] k, keep, sum, over, wsum, hsum;
		logic          last;
		logic          ovalid;
		head_d  = head_q;
		fill_d  = fill_q;
		htg_d   = htg_q;
		ltime_d = ltime_q;
		held_d  = held_q;
		rel_d   = rel_q;
		disc_d  = disc_q;
		act_d   = act_q;
		emit_d  = emit_q;
		drain_d = drain_q;
		frem_d  = frem_q;
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = item.sample_in;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		last   = 1'b0;
		ovalid = 1'b0;
		fill_div = div160(17'(fill_q));
		n_div    = div160(17'(item.frame_len));
		tgchg = (fill_q != '0) && (item.talkgroup != '0) && (htg_q != '0)
			&& (item.talkgroup != htg_q);
		k = '0; keep = '0; sum = '0; over = '0;
		wsum = XW'(head_q) + XW'(fill_q);
		if (wsum >= DEPTH_X) wsum = wsum - DEPTH_X;
		hsum = XW'(head_q) + XW'(1);
		if (hsum >= DEPTH_X) hsum = '0;

		unique case (item.mode)
			MODE_HEADER: begin
				drain_d = '0;
				emit_d  = '0;
				frem_d  = item.frame_len;
				if (tgchg) begin
					disc_d = disc_d + fill_div;
					fill_d = '0;
					htg_d  = '0;
				end
				if (item.sync_valid && item.algorithm_id == ALG_CLEAR) begin
					k = (XW'(fill_d) < XW'(cap_q)) ? XW'(fill_d) : XW'(cap_q);
					if (!tgchg) rel_d = rel_d + fill_div;
					fill_d  = '0;
					htg_d   = '0;
					drain_d = FW'(k);
					emit_d  = 14'(k);
					act_d   = (k != '0) ? ACT_RELEASE : ACT_PASS;
				end else if (item.sync_valid) begin
					if (!tgchg) disc_d = disc_d + fill_div;
					fill_d = '0;
					htg_d  = '0;
					if (item.unproven) begin
						held_d = held_d + n_div;
						disc_d = disc_d + n_div;
						act_d  = ACT_DROP;
					end else begin
						act_d = ACT_PASS;
					end
				end else if (!item.unproven) begin
					act_d = ACT_PASS;
				end else begin
					act_d = ACT_HOLD;
					if (item.frame_len != '0) begin
						held_d = held_d + n_div;
						keep = XW'(item.frame_len);
						if (32'(item.frame_len) > 32'(DEPTH)) begin
							disc_d = disc_d + div160(17'(32'(item.frame_len) - 32'(DEPTH)));
							keep = DEPTH_X;
						end
						sum = XW'(fill_d) + keep;
						if (sum > DEPTH_X) begin
							over = sum - DEPTH_X;
							hsum = XW'(head_q) + over;
							if (hsum >= DEPTH_X) hsum = hsum - DEPTH_X;
							head_d = AW'(hsum);
							fill_d = fill_d - FW'(over);
							disc_d = disc_d + div160(17'(over));
						end
						if (item.talkgroup != '0) htg_d = item.talkgroup;
						ltime_d = item.now_ms;
					end
				end
			end
			MODE_SAMPLE: begin
				if (frem_q != '0) begin
					frem_d = frem_q - 14'd1;
					if (act_q == ACT_HOLD) begin
						mem_we = 1'b1;
						if (XW'(fill_q) >= DEPTH_X) begin
							mem_waddr = head_q;
							head_d = AW'(hsum);
						end else begin
							mem_waddr = AW'(wsum);
							fill_d = fill_q + FW'(1);
						end
					end else if (act_q != ACT_DROP) begin
						if (emit_q < cap_q) begin
							emit_d = emit_q + 14'd1;
							ovalid = 1'b1;
						end
					end
				end
			end
			MODE_TICK: begin
				if (fill_q != '0 && (item.now_ms - ltime_q) > 32'(age_q)) begin
					disc_d = disc_d + fill_div;
					fill_d = '0;
					htg_d  = '0;
				end
			end
			MODE_END: begin
				if (fill_q != '0) begin
					disc_d = disc_d + fill_div;
					fill_d = '0;
					htg_d  = '0;
				end
			end
			MODE_DRAIN: begin
				if (drain_q != '0) begin
					mem_re  = 1'b1;
					head_d  = AW'(hsum);
					drain_d = drain_q - FW'(1);
					ovalid  = 1'b1;
					if (drain_q == FW'(1)) begin
						last = 1'b1;
						if (act_q == ACT_RELEASE) act_d = ACT_PASS;
					end
				end
			end
			default: begin
			end
		endcase

		mem_we = mem_we & acc;
		mem_re = mem_re & acc;
		res.from_ring             = (item.mode == MODE_DRAIN) && ovalid;
		res.item.out_valid        = ovalid;
		res.item.out_sample       = ovalid ? item.sample_in : 16'sd0;
		res.item.drain_last       = last;
		res.item.frame_action     = act_d;
		res.item.held_count       = 13'(fill_d);
		res.item.frames_held      = held_d;
		res.item.frames_released  = rel_d;
		res.item.frames_discarded = disc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			age_q <= AGE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OUTPUT_CAP) cap_q <= cfg_data[13:0];
			if (cfg_index == CFG_MAX_AGE)    age_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
			htg_q   <= '0;
			ltime_q <= '0;
			held_q  <= '0;
			rel_q   <= '0;
			disc_q  <= '0;
			act_q   <= ACT_PASS;
			emit_q  <= '0;
			drain_q <= '0;
			frem_q  <= '0;
		end else if (acc) begin
			head_q  <= head_d;
			fill_q  <= fill_d;
			htg_q   <= htg_d;
			ltime_q <= ltime_d;
			held_q  <= held_d;
			rel_q   <= rel_d;
			disc_q  <= disc_d;
			act_q   <= act_d;
			emit_q  <= emit_d;
			drain_q <= drain_d;
			frem_q  <= frem_d;
		end
	end
endmodule

/* rtl/vhrg_checker.sv */
// Port-level checks for the voice hold/release gate and the bind that attaches them.
// Uses vhrg_pkg.
module vhrg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input vhrg_pkg::out_t out_data,
	input logic           cfg_ready
);
	import vhrg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	a_last_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drain_last |->
		out_data.out_valid && out_data.frame_action == ACT_PASS)
		else $error("last drained beat without pass action");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind voice_hold_release_gate_unit vhrg_checker u_vhrg_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
	.cfg_ready(cfg_ready)
);
